// ===== hdl/chcw_pkg.sv =====
// shared constants, types and tables for the cosine hemisphere concentric warp
package chcw_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int AB_W       = SAMPLE_BITS + 2;
    localparam int MAG_W      = SAMPLE_BITS + 1;
    localparam int Q_W        = 17;
    localparam int REM_W      = MAG_W + 1;
    localparam int DIV_STEPS  = Q_W;
    localparam int ANG_W      = 32;
    localparam int TPROD_W    = Q_W + 30;
    localparam int PROD_W     = AB_W + ANG_W;
    localparam int ROUND_SH   = SAMPLE_BITS + 15;
    localparam int SQ_W       = 31;
    localparam int ROOT_STEPS = 16;
    localparam int OUT_W      = 16;
    localparam int Z_W        = 15;

    localparam logic [29:0] PI4_Q30 = 30'h3243F6A8;
    localparam logic signed [ANG_W-1:0] KGAIN_Q30 = 32'sh26DD3B6A;

    localparam logic signed [ANG_W-1:0] ATAN_Q30 [32] = '{
        32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
        32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
        32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
        32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
        32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
        32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F,
        32'sh0000003F, 32'sh0000001F, 32'sh0000000F, 32'sh00000007,
        32'sh00000003, 32'sh00000001, 32'sh00000000, 32'sh00000000
    };

    typedef enum logic [1:0] {
        REGION_K0,
        REGION_K2,
        REGION_K4,
        REGION_K6
    } region_t;

    typedef struct packed {
        logic                   center;
        logic                   neg;
        region_t                region;
        logic signed [AB_W-1:0] radius;
    } side_t;

endpackage

// ===== hdl/chcw_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module chcw_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_vld,
    input  logic [chcw_pkg::MAG_W-1:0] an,
    input  logic [chcw_pkg::MAG_W-1:0] ad,
    input  chcw_pkg::side_t            side_in,
    output logic                       out_vld,
    output logic [chcw_pkg::Q_W-1:0]   q,
    output chcw_pkg::side_t            side_out
);
    import chcw_pkg::*;

    logic [REM_W-1:0]     rem_reg  [DIV_STEPS];
    logic [Q_W-1:0]       q_reg    [DIV_STEPS];
    logic [MAG_W-1:0]     ad_reg   [DIV_STEPS];
    side_t                side_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] vld_reg;

    logic [REM_W-1:0] rem_in   [DIV_STEPS];
    logic [REM_W-1:0] diff     [DIV_STEPS];
    logic [REM_W-1:0] rem_next [DIV_STEPS];
    logic [Q_W-1:0]   q_in     [DIV_STEPS];
    logic [Q_W-1:0]   q_next   [DIV_STEPS];
    logic [MAG_W-1:0] ad_in    [DIV_STEPS];
    side_t            side_in_s[DIV_STEPS];
    logic [DIV_STEPS-1:0] ge;

    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (j == 0)
            begin
                rem_in[j]    = {1'b0, an};
                q_in[j]      = '0;
                ad_in[j]     = ad;
                side_in_s[j] = side_in;
            end
            else
            begin
                rem_in[j]    = rem_reg[j-1];
                q_in[j]      = q_reg[j-1];
                ad_in[j]     = ad_reg[j-1];
                side_in_s[j] = side_reg[j-1];
            end
            ge[j]       = rem_in[j] >= {1'b0, ad_in[j]};
            diff[j]     = ge[j] ? rem_in[j] - {1'b0, ad_in[j]} : rem_in[j];
            rem_next[j] = {diff[j][REM_W-2:0], 1'b0};
            q_next[j]   = {q_in[j][Q_W-2:0], ge[j]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                ad_reg[j]   <= ad_in[j];
                side_reg[j] <= side_in_s[j];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STEPS-1];
    assign q        = q_reg[DIV_STEPS-1];
    assign side_out = side_reg[DIV_STEPS-1];

endmodule

// ===== hdl/chcw_cordic.sv =====
// pipelined rotation cordic, one micro-rotation per stage
module chcw_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic signed [chcw_pkg::ANG_W-1:0] theta,
    input  chcw_pkg::side_t                   side_in,
    output logic                              out_vld,
    output logic signed [chcw_pkg::ANG_W-1:0] cos_q30,
    output logic signed [chcw_pkg::ANG_W-1:0] sin_q30,
    output chcw_pkg::side_t                   side_out
);
    import chcw_pkg::*;

    logic signed [ANG_W-1:0] x_reg [CORDIC_STAGES];
    logic signed [ANG_W-1:0] y_reg [CORDIC_STAGES];
    logic signed [ANG_W-1:0] z_reg [CORDIC_STAGES];
    side_t                   side_reg [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] vld_reg;

    logic signed [ANG_W-1:0] x_in [CORDIC_STAGES];
    logic signed [ANG_W-1:0] y_in [CORDIC_STAGES];
    logic signed [ANG_W-1:0] z_in [CORDIC_STAGES];
    logic signed [ANG_W-1:0] x_next [CORDIC_STAGES];
    logic signed [ANG_W-1:0] y_next [CORDIC_STAGES];
    logic signed [ANG_W-1:0] z_next [CORDIC_STAGES];
    side_t                   side_s [CORDIC_STAGES];

    always_comb
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (i == 0)
            begin
                x_in[i]   = KGAIN_Q30;
                y_in[i]   = '0;
                z_in[i]   = theta;
                side_s[i] = side_in;
            end
            else
            begin
                x_in[i]   = x_reg[i-1];
                y_in[i]   = y_reg[i-1];
                z_in[i]   = z_reg[i-1];
                side_s[i] = side_reg[i-1];
            end
            if (!z_in[i][ANG_W-1])
            begin
                x_next[i] = x_in[i] - (y_in[i] >>> i);
                y_next[i] = y_in[i] + (x_in[i] >>> i);
                z_next[i] = z_in[i] - ATAN_Q30[i];
            end
            else
            begin
                x_next[i] = x_in[i] + (y_in[i] >>> i);
                y_next[i] = y_in[i] - (x_in[i] >>> i);
                z_next[i] = z_in[i] + ATAN_Q30[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[CORDIC_STAGES-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                side_reg[i] <= side_s[i];
            end
        end
    end

    assign out_vld  = vld_reg[CORDIC_STAGES-1];
    assign cos_q30  = x_reg[CORDIC_STAGES-1];
    assign sin_q30  = y_reg[CORDIC_STAGES-1];
    assign side_out = side_reg[CORDIC_STAGES-1];

endmodule

// ===== hdl/cosine_hemisphere_concentric_warp_unit.sv =====
// top level of the cosine hemisphere concentric warp
//
// takes a unit-square sample (u_sample, v_sample, unsigned q0.16) on the
// sample channel and returns the concentric disk point (disk_x, disk_y,
// signed q1.15) with the hemisphere height hemi_z (q0.15, at least 1 lsb)
// on the result channel. both channels use valid and stall.
// the pipeline is 57 stages deep. one transaction enters per cycle while
// the result channel does not stall; the depth is set by the 17-step
// divider, the 16-stage cordic and the 16-step square root, one step per
// register stage.
// every stage advances together; when the result channel stalls with a
// result on its port the whole pipeline holds and sample_stall is raised,
// so nothing is lost or repeated.
// reset clears all valid bits; the first sample can be taken right after.
module cosine_hemisphere_concentric_warp_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [15:0]                        u_sample,
    input  logic [15:0]                        v_sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [chcw_pkg::OUT_W-1:0]  disk_x,
    output logic signed [chcw_pkg::OUT_W-1:0]  disk_y,
    output logic [chcw_pkg::Z_W-1:0]           hemi_z
);
    import chcw_pkg::*;

    localparam logic signed [AB_W-1:0] ONE_AB = AB_W'(1) <<< SAMPLE_BITS;

    logic en;
    assign en           = !(result_valid && result_stall);
    assign sample_stall = !en;

    // region select
    logic signed [AB_W-1:0] a, b, num, den;
    side_t side0_next;
    logic [MAG_W-1:0] an_next, ad_next;
    logic signed [AB_W-1:0] an_abs, ad_abs;

    always_comb
    begin
        a = $signed({1'b0, u_sample[SAMPLE_BITS-1:0], 1'b0}) - ONE_AB;
        b = $signed({1'b0, v_sample[SAMPLE_BITS-1:0], 1'b0}) - ONE_AB;
        if (a > -b)
        begin
            if (a > b)
            begin
                side0_next.radius = a;  num = b;  den = a;
                side0_next.region = REGION_K0;
            end
            else
            begin
                side0_next.radius = b;  num = -a; den = b;
                side0_next.region = REGION_K2;
            end
        end
        else
        begin
            if (a < b)
            begin
                side0_next.radius = -a; num = b;  den = a;
                side0_next.region = REGION_K4;
            end
            else
            begin
                side0_next.radius = -b; num = -a; den = b;
                side0_next.region = REGION_K6;
            end
        end
        an_abs = num[AB_W-1] ? -num : num;
        ad_abs = den[AB_W-1] ? -den : den;
        an_next = an_abs[MAG_W-1:0];
        ad_next = ad_abs[MAG_W-1:0];
        side0_next.neg    = num[AB_W-1] != den[AB_W-1];
        side0_next.center = (a == '0) && (b == '0);
    end

    logic [MAG_W-1:0] an_reg, ad_reg;
    side_t            side0_reg;
    logic             v0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an_reg    <= an_next;
            ad_reg    <= ad_next;
            side0_reg <= side0_next;
        end
    end

    // ratio
    logic           v1;
    logic [Q_W-1:0] q1;
    side_t          side1;

    chcw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v0_reg),
        .an       (an_reg),
        .ad       (ad_reg),
        .side_in  (side0_reg),
        .out_vld  (v1),
        .q        (q1),
        .side_out (side1)
    );

    // angle
    logic [TPROD_W-1:0]      tprod_reg;
    side_t                   side_t1_reg;
    logic                    vt1_reg;
    logic signed [ANG_W-1:0] theta_reg, theta_next;
    side_t                   side_t2_reg;
    logic                    vt2_reg;
    logic signed [ANG_W-1:0] theta_mag;

    always_comb
    begin
        theta_mag  = $signed({1'b0, tprod_reg[TPROD_W-1:16]});
        theta_next = side_t1_reg.neg ? -theta_mag : theta_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt1_reg <= 1'b0;
            vt2_reg <= 1'b0;
        end
        else if (en)
        begin
            vt1_reg <= v1;
            vt2_reg <= vt1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tprod_reg   <= TPROD_W'(q1) * TPROD_W'(PI4_Q30);
            side_t1_reg <= side1;
            theta_reg   <= theta_next;
            side_t2_reg <= side_t1_reg;
        end
    end

    // sine and cosine
    logic                    v3;
    logic signed [ANG_W-1:0] c3, s3;
    side_t                   side3;

    chcw_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vt2_reg),
        .theta    (theta_reg),
        .side_in  (side_t2_reg),
        .out_vld  (v3),
        .cos_q30  (c3),
        .sin_q30  (s3),
        .side_out (side3)
    );

    // quarter turn and scale
    logic signed [ANG_W-1:0]  cs, sn;
    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic                     center_m_reg, vm_reg;

    always_comb
    begin
        case (side3.region)
            REGION_K0: begin cs = c3;  sn = s3;  end
            REGION_K2: begin cs = -s3; sn = c3;  end
            REGION_K4: begin cs = -c3; sn = -s3; end
            default:   begin cs = s3;  sn = -c3; end
        endcase
    end

    logic signed [PROD_W-1:0] rx, ry;
    logic signed [OUT_W-1:0]  x_next, y_next, x_reg, y_reg;
    logic                     vr_reg;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi, lo;
        hi = PROD_W'(32767);
        lo = -PROD_W'(32768);
        if (v > hi)
            return OUT_W'(32767);
        else if (v < lo)
            return OUT_W'(-32768);
        else
            return v[OUT_W-1:0];
    endfunction

    always_comb
    begin
        rx = (px_reg + (PROD_W'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        ry = (py_reg + (PROD_W'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        x_next = center_m_reg ? '0 : sat_out(rx);
        y_next = center_m_reg ? '0 : sat_out(ry);
    end

    // squares and height argument
    logic signed [2*OUT_W-1:0] xe, ye, xx_full, yy_full;
    logic [SQ_W-1:0]           xx_reg, yy_reg;
    logic signed [OUT_W-1:0]   x_sq_reg, y_sq_reg;
    logic                      vsq_reg;
    logic [SQ_W+1:0]           s_full;
    logic [SQ_W-1:0]           n_next;

    always_comb
    begin
        xe      = (2*OUT_W)'(x_reg);
        ye      = (2*OUT_W)'(y_reg);
        xx_full = xe * xe;
        yy_full = ye * ye;
        s_full  = ((SQ_W+2)'(1) << 30) - (SQ_W+2)'(xx_reg) - (SQ_W+2)'(yy_reg);
        n_next  = (!s_full[SQ_W+1] && s_full != '0) ? s_full[SQ_W-1:0] : '0;
    end

    logic [SQ_W-1:0]         n0_reg;
    logic signed [OUT_W-1:0] x_n_reg, y_n_reg;
    logic                    vn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg  <= 1'b0;
            vr_reg  <= 1'b0;
            vsq_reg <= 1'b0;
            vn_reg  <= 1'b0;
        end
        else if (en)
        begin
            vm_reg  <= v3;
            vr_reg  <= vm_reg;
            vsq_reg <= vr_reg;
            vn_reg  <= vsq_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg       <= PROD_W'(side3.radius) * PROD_W'(cs);
            py_reg       <= PROD_W'(side3.radius) * PROD_W'(sn);
            center_m_reg <= side3.center;
            x_reg        <= x_next;
            y_reg        <= y_next;
            xx_reg       <= xx_full[SQ_W-1:0];
            yy_reg       <= yy_full[SQ_W-1:0];
            x_sq_reg     <= x_reg;
            y_sq_reg     <= y_reg;
            n0_reg       <= n_next;
            x_n_reg      <= x_sq_reg;
            y_n_reg      <= y_sq_reg;
        end
    end

    // square root, one result bit per stage
    logic [SQ_W-1:0]           rn_reg [ROOT_STEPS];
    logic [SQ_W-1:0]           rr_reg [ROOT_STEPS];
    logic signed [OUT_W-1:0]   rx_reg [ROOT_STEPS];
    logic signed [OUT_W-1:0]   ry_reg [ROOT_STEPS];
    logic [ROOT_STEPS-1:0]     vq_reg;

    logic [SQ_W-1:0] n_in [ROOT_STEPS];
    logic [SQ_W-1:0] r_in [ROOT_STEPS];
    logic [SQ_W-1:0] n_nx [ROOT_STEPS];
    logic [SQ_W-1:0] r_nx [ROOT_STEPS];
    logic [SQ_W:0]   trial [ROOT_STEPS];
    logic [SQ_W-1:0] bitv [ROOT_STEPS];
    logic signed [OUT_W-1:0] xq_in [ROOT_STEPS];
    logic signed [OUT_W-1:0] yq_in [ROOT_STEPS];

    always_comb
    begin
        for (int j = 0; j < ROOT_STEPS; j++)
        begin
            if (j == 0)
            begin
                n_in[j]  = n0_reg;
                r_in[j]  = '0;
                xq_in[j] = x_n_reg;
                yq_in[j] = y_n_reg;
            end
            else
            begin
                n_in[j]  = rn_reg[j-1];
                r_in[j]  = rr_reg[j-1];
                xq_in[j] = rx_reg[j-1];
                yq_in[j] = ry_reg[j-1];
            end
            bitv[j]  = SQ_W'(1) << (2 * (ROOT_STEPS - 1 - j));
            trial[j] = {1'b0, r_in[j]} + {1'b0, bitv[j]};
            if ({1'b0, n_in[j]} >= trial[j])
            begin
                n_nx[j] = n_in[j] - trial[j][SQ_W-1:0];
                r_nx[j] = (r_in[j] >> 1) + bitv[j];
            end
            else
            begin
                n_nx[j] = n_in[j];
                r_nx[j] = r_in[j] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg <= '0;
        else if (en)
            vq_reg <= {vq_reg[ROOT_STEPS-2:0], vn_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < ROOT_STEPS; j++)
            begin
                rn_reg[j] <= n_nx[j];
                rr_reg[j] <= r_nx[j];
                rx_reg[j] <= xq_in[j];
                ry_reg[j] <= yq_in[j];
            end
        end
    end

    // output register
    logic [SQ_W-1:0]         root;
    logic [Z_W-1:0]          z_next;
    logic signed [OUT_W-1:0] dx_reg, dy_reg;
    logic [Z_W-1:0]          z_reg;
    logic                    vo_reg;

    always_comb
    begin
        root = rr_reg[ROOT_STEPS-1];
        if (root > SQ_W'(32767))
            z_next = '1;
        else if (root == '0)
            z_next = Z_W'(1);
        else
            z_next = root[Z_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= vq_reg[ROOT_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= rx_reg[ROOT_STEPS-1];
            dy_reg <= ry_reg[ROOT_STEPS-1];
            z_reg  <= z_next;
        end
    end

    assign result_valid = vo_reg;
    assign disk_x       = dx_reg;
    assign disk_y       = dy_reg;
    assign hemi_z       = z_reg;

endmodule
